FILE: hdl/base32_byte_encoder_macros.svh
// Assertion macros shared by the base32 encoder RTL.
`ifndef BASE32_BYTE_ENCODER_MACROS_SVH
`define BASE32_BYTE_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds on every clock edge outside reset.
`define B32E_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never becomes true outside reset.
`define B32E_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define B32E_ASSERT(lbl, clk, rstn, prop, msg)
`define B32E_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

FILE: hdl/b32e_pkg.sv
// Types, constants and lookup functions of the base32 byte encoder.
package b32e_pkg;

	localparam int GROUP_BYTES   = 5;
	localparam int GROUP_BITS    = 8 * GROUP_BYTES;
	localparam int SYMS_PER_GRP  = 8;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic ALPHA_ZBASE32 = 1'b0;
	localparam logic ALPHA_RFC4648 = 1'b1;

	localparam logic [0:31][7:0] ZB32_TABLE = "ybndrfg8ejkmcpqxot1uwisza345h769";
	localparam logic [0:31][7:0] RFC_TABLE  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

	// One flushed group, as it waits between front and back.
	typedef struct packed {
		logic [GROUP_BITS-1:0] group;
		logic [2:0]            pads;
		logic                  last;
		logic                  alpha;
	} group_entry_t;

	// Head of the group queue as the back end sees it.
	typedef struct packed {
		logic         valid;
		group_entry_t entry;
	} queue_head_t;

	// Number of '=' symbols for a final group of n bytes.
	function automatic logic [2:0] pad_count(input logic [2:0] n);
		logic [2:0] p;
		case (n)
			3'd1:    p = 3'd6;
			3'd2:    p = 3'd4;
			3'd3:    p = 3'd3;
			3'd4:    p = 3'd1;
			default: p = 3'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] symbol_of(input logic alpha, input logic [4:0] idx);
		logic [7:0] s;
		if (alpha == ALPHA_RFC4648) begin
			s = RFC_TABLE[idx];
		end else begin
			s = ZB32_TABLE[idx];
		end
		return s;
	endfunction

endpackage

FILE: hdl/b32e_front.sv
// Front end: collects bytes into groups and pushes flushed groups.
module b32e_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tlast,
	input  logic                  queue_full,
	output logic                  push,
	output b32e_pkg::group_entry_t push_entry
);

	logic [31:0] pending_q;
	logic [2:0]  count_q;
	logic        alpha_q;
	logic        accept;
	logic        flush;
	logic [2:0]  n;

	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign flush    = s_tlast || (count_q == 3'd4);
	assign push     = accept && flush;
	assign n        = count_q + 3'd1;

	always_comb begin
		case (count_q)
			3'd0:    push_entry.group = {s_tdata, 32'd0};
			3'd1:    push_entry.group = {pending_q[7:0], s_tdata, 24'd0};
			3'd2:    push_entry.group = {pending_q[15:0], s_tdata, 16'd0};
			3'd3:    push_entry.group = {pending_q[23:0], s_tdata, 8'd0};
			default: push_entry.group = {pending_q, s_tdata};
		endcase
		push_entry.pads  = s_tlast ? b32e_pkg::pad_count(n) : 3'd0;
		push_entry.last  = s_tlast;
		push_entry.alpha = alpha_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			count_q   <= '0;
			alpha_q   <= b32e_pkg::ALPHA_ZBASE32;
		end else begin
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end
			if (accept) begin
				if (flush) begin
					pending_q <= '0;
					count_q   <= '0;
				end else begin
					pending_q <= {pending_q[23:0], s_tdata};
					count_q   <= n;
				end
			end
		end
	end

endmodule

FILE: hdl/b32e_queue.sv
// Short queue of flushed groups between front and back end.
`include "base32_byte_encoder_macros.svh"
module b32e_queue #(
	parameter int DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  b32e_pkg::group_entry_t push_entry,
	output logic                   full,
	input  logic                   pop,
	output b32e_pkg::queue_head_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b32e_pkg::group_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`B32E_NEVER(a_push_full, clk, arst_n, push && full, "group pushed into full queue")
	`B32E_NEVER(a_pop_empty, clk, arst_n, pop && !head.valid, "group popped from empty queue")

endmodule

FILE: hdl/b32e_back.sv
// Back end: turns each queued group into eight symbols, one per cycle while the receiver is ready.
`include "base32_byte_encoder_macros.svh"
module b32e_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b32e_pkg::queue_head_t head,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);

	logic [2:0]       k_q;
	logic             out_valid_q;
	logic [7:0]       sym_q;
	logic             last_q;
	logic             load;
	logic [7:0][4:0]  slices;
	logic [4:0]       idx;
	logic [3:0]       pad_sum;
	logic [7:0]       sym;

	assign slices  = head.entry.group;
	assign idx     = slices[3'd7 - k_q];
	assign pad_sum = {1'b0, k_q} + {1'b0, head.entry.pads};
	assign sym     = pad_sum[3] ? b32e_pkg::PAD_CHAR
	                            : b32e_pkg::symbol_of(head.entry.alpha, idx);

	assign load = head.valid && (!out_valid_q || m_tready);
	assign pop  = load && (k_q == 3'd7);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sym_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			sym_q  <= sym;
			last_q <= head.entry.last && (k_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q         <= k_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`B32E_ASSERT(a_mid_group, clk, arst_n, (k_q != 3'd0) |-> head.valid,
		"symbol counter mid-group without a queued group")
	`B32E_ASSERT(a_pop_loads, clk, arst_n, pop |=> m_tvalid,
		"group retired without its final symbol in the output register")

endmodule

FILE: hdl/base32_byte_encoder.sv
// The first symbol of a group reaches the output register by way of the group queue after its flushing byte is taken.
// The back end emits one symbol per cycle while the receiver is ready and a group is queued;
// each group of up to five bytes yields eight symbols.
// The group queue lets the front take bytes while the back end drains a group.
// Reset (arst_n low, asynchronous) empties the queue and pending bytes and
// selects the z-base-32 alphabet.
module base32_byte_encoder #(
	parameter int QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// alphabet select: 0 z-base-32, 1 RFC 4648
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // last_of_message
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] symbol
	output logic       m_tlast    // last_symbol
);

	// Front to queue request and queue status.
	logic                   push;
	logic                   queue_full;
	b32e_pkg::group_entry_t push_entry;

	// Queue head to back end and the retire request back.
	b32e_pkg::queue_head_t  head;
	logic                   pop;

	// Collect bytes; push a group on the fifth byte or the last one.
	b32e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Hold flushed groups so either side can stall on its own.
	b32e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head       (head)
	);

	// Serialize each group into eight symbols through the output register.
	b32e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: tb/base32_byte_encoder_test.sv
// Self-checking testbench for the base32 byte encoder with a scoreboard built in.
`timescale 1ns / 1ps

module base32_byte_encoder_test;

	localparam int QUIET_LIMIT  = 1000; // cycles without any handshake before giving up
	localparam int SETTLE_WAIT  = 8;    // covers the path through the group queue and output register with margin
	localparam int LONG_HOLD    = 150;  // receiver hold-off that backs up the input side

	localparam logic [7:0] EQUALS_SIGN = 8'h3D;
	localparam logic [0:31][7:0] ZB_LETTERS  = "ybndrfg8ejkmcpqxot1uwisza345h769";
	localparam logic [0:31][7:0] RFC_LETTERS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} byte_req_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       is_last;
	} symbol_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;
	logic       s_tlast   = 1'b0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	byte_req_t bytes_to_send[$];
	symbol_t   symbols_due[$];

	// Shadow of the encoder state
	logic [31:0] held_bytes  = '0;
	int          held_count  = 0;
	logic        alpha_shadow = b32e_pkg::ALPHA_ZBASE32;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_asks     = 0;
	int  hold_given    = 0;
	int  hold_left     = 0;
	int  quiet_cycles  = 0;
	int  mismatches    = 0;
	bit  req_taken     = 1'b0;

	base32_byte_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	// Advance the shadow state by one accepted request and queue any symbols it flushes.
	task automatic encode_byte(input logic [7:0] data, input logic is_last);
		int          n;
		int          pads;
		logic [63:0] grp;
		logic [4:0]  idx;
		symbol_t     sym;
		n = (held_count > 4) ? 5 : held_count + 1;
		if (n < 5 && !is_last) begin
			held_bytes = {held_bytes[23:0], data};
			held_count = n;
			return;
		end
		// Keep only the n newest bytes, then left-align them in 40 bits
		grp = {24'h0, held_bytes, data};
		grp = grp & ((64'd1 << (8 * n)) - 64'd1);
		grp = grp << (8 * (5 - n));
		case (n)
			1:       pads = 6;
			2:       pads = 4;
			3:       pads = 3;
			4:       pads = 1;
			default: pads = 0;
		endcase
		if (!is_last) begin
			pads = 0;
		end
		for (int k = 0; k < 8; k++) begin
			idx = grp[35 - 5 * k +: 5];
			if (k >= 8 - pads) begin
				sym.symbol = EQUALS_SIGN;
			end else if (alpha_shadow == b32e_pkg::ALPHA_RFC4648) begin
				sym.symbol = RFC_LETTERS[idx];
			end else begin
				sym.symbol = ZB_LETTERS[idx];
			end
			sym.is_last = is_last && (k == 7);
			symbols_due.push_back(sym);
		end
		held_bytes = '0;
		held_count = 0;
	endtask

	// Sender: hold a request until it is taken, then offer the next or idle.
	always @(negedge clk) begin : drive_requests
		byte_req_t nxt;
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = bytes_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= nxt.data;
				s_tlast  <= nxt.is_last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	always @(negedge clk) begin : drive_ready
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_asks != hold_given) begin
			hold_given = hold_given + 1;
			hold_left  = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Both handshakes are sampled here; predict on input, compare on output.
	always @(posedge clk) begin : watch_streams
		symbol_t want;
		bit      sym_taken;
		req_taken = arst_n && s_tvalid && s_tready;
		sym_taken = arst_n && m_tvalid && m_tready;
		if (req_taken) begin
			encode_byte(s_tdata, s_tlast);
		end
		if (sym_taken) begin
			if (symbols_due.size() == 0) begin
				note_mismatch($sformatf("unexpected symbol %02h last %0b", m_tdata, m_tlast));
			end else begin
				want = symbols_due.pop_front();
				if (m_tdata !== want.symbol) begin
					note_mismatch($sformatf("symbol %02h, want %02h", m_tdata, want.symbol));
				end
				if (m_tlast !== want.is_last) begin
					note_mismatch($sformatf("last_symbol %0b, want %0b on %02h",
						m_tlast, want.is_last, want.symbol));
				end
			end
		end
		// Watchdog: count cycles in which nothing moves
		if (req_taken || sym_taken || cfg_we || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d quiet cycles, %0d symbols due", quiet_cycles,
				symbols_due.size());
			$display("[base32_byte_encoder] ERROR");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] data, input logic is_last);
		byte_req_t r;
		r.data    = data;
		r.is_last = is_last;
		bytes_to_send.push_back(r);
	endtask

	// Bias toward all-zero and all-one bytes so both slice extremes show up often.
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(7))
			0:       b = 8'h00;
			1:       b = 8'hFF;
			default: b = 8'($urandom);
		endcase
		return b;
	endfunction

	// Queue whole messages until at least count bytes are queued.
	task automatic queue_messages(input int count);
		int queued;
		int len;
		queued = 0;
		while (queued < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				push_byte(pick_byte(), i == len - 1);
			end
			queued += len;
		end
	endtask

	// Wait until every queued request has been taken (both change only at negedge).
	task automatic drain_requests();
		while (bytes_to_send.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
	endtask

	// Wait until every predicted symbol has come out (the queue changes only at posedge).
	task automatic wait_symbols();
		@(negedge clk);
		while (symbols_due.size() != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Write the alphabet register; only called with no requests pending and no symbols due.
	task automatic write_alphabet(input logic sel);
		repeat (SETTLE_WAIT) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= sel;
		alpha_shadow = sel;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_alphabet(b32e_pkg::ALPHA_ZBASE32);
		send_idle_pct = 29;
		recv_idle_pct = 76;

		// Directed: every short-group padding, full groups at and before the end
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hA5, 1'b0);
		push_byte(8'h5A, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h56, 1'b0);
		push_byte(8'h78, 1'b1);
		for (int i = 0; i < 5; i++) begin
			push_byte(8'hFF, i == 4);
		end
		for (int i = 0; i < 5; i++) begin
			push_byte(8'h00, 1'b0);
		end
		// Leave three bytes held so the alphabet switch lands mid-group
		push_byte(8'h84, 1'b0);
		push_byte(8'h21, 1'b0);
		push_byte(8'h08, 1'b0);
		drain_requests();
		wait_symbols();
		write_alphabet(b32e_pkg::ALPHA_RFC4648);

		// Sender mostly busy, receiver mostly stalled; pause the sender halfway
		queue_messages(60);
		drain_requests();
		wait_symbols();
		queue_messages(60);
		drain_requests();
		wait_symbols();
		write_alphabet(b32e_pkg::ALPHA_ZBASE32);

		// Sender mostly idle, receiver mostly ready
		send_idle_pct = 76;
		recv_idle_pct = 29;
		queue_messages(120);
		drain_requests();
		wait_symbols();
		write_alphabet(b32e_pkg::ALPHA_RFC4648);

		// No idling; hold the receiver off so the group queue fills and input stalls
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_messages(50);
		hold_asks = hold_asks + 1;
		queue_messages(60);
		drain_requests();
		wait_symbols();
		repeat (SETTLE_WAIT) @(posedge clk);

		if (mismatches == 0) begin
			$display("[base32_byte_encoder] OK");
		end else begin
			$display("[base32_byte_encoder] ERROR");
		end
		$finish;
	end

endmodule
